// ===== sv/tpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tpc_pkg
// Shared constants for the triangle point containment unit: default widths,
// coordinate slot numbering, pipeline depth and configuration register map.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int DEF_COORD_WIDTH      = 16;
  localparam int DEF_MARGIN_FRAC_BITS = 16;

  localparam int MARGIN_WIDTH = 16;
  localparam int NUM_COORDS   = 8;
  localparam int NUM_STAGES   = 8;

  localparam int APB_DATA_WIDTH = 32;
  localparam int APB_ADDR_WIDTH = 3;

  localparam logic [APB_ADDR_WIDTH-3:0] REG_MARGIN = 1'b0;

  localparam int IDX_AX = 0;
  localparam int IDX_AY = 1;
  localparam int IDX_BX = 2;
  localparam int IDX_BY = 3;
  localparam int IDX_CX = 4;
  localparam int IDX_CY = 5;
  localparam int IDX_QX = 6;
  localparam int IDX_QY = 7;

endpackage

// ===== sv/tpc_if.sv =====
// ----------------------------------------------------------------------------
// Channel interfaces
// Query channel carrying three vertices and a point, and result channel
// carrying the containment flag, each with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpc_in_if #(
  parameter int COORD_WIDTH = tpc_pkg::DEF_COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_a_x;
  logic signed [COORD_WIDTH-1:0] vertex_a_y;
  logic signed [COORD_WIDTH-1:0] vertex_b_x;
  logic signed [COORD_WIDTH-1:0] vertex_b_y;
  logic signed [COORD_WIDTH-1:0] vertex_c_x;
  logic signed [COORD_WIDTH-1:0] vertex_c_y;
  logic signed [COORD_WIDTH-1:0] query_x;
  logic signed [COORD_WIDTH-1:0] query_y;

  modport source (
    output valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, query_x, query_y,
    input  ready
  );

  modport sink (
    input  valid, vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y,
           vertex_c_x, vertex_c_y, query_x, query_y,
    output ready
  );
endinterface

interface tpc_out_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

// ===== sv/tpc_pipe.sv =====
// ----------------------------------------------------------------------------
// tpc_pipe
// Eight-stage datapath of the barycentric containment test: edge vectors,
// cross products, determinant and numerators, sign normalization, margin
// product, shifted operands, and the final signed compares.
// ----------------------------------------------------------------------------
module tpc_pipe #(
  parameter int COORD_WIDTH      = tpc_pkg::DEF_COORD_WIDTH,
  parameter int MARGIN_FRAC_BITS = tpc_pkg::DEF_MARGIN_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_coord [tpc_pkg::NUM_COORDS],
  input  logic [tpc_pkg::MARGIN_WIDTH-1:0] margin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_inside
);
  import tpc_pkg::*;

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int NW = PW + 1;
  localparam int SW = NW + 1;
  localparam int MW = MARGIN_WIDTH;
  localparam int LW = (NW + 1) / 2;
  localparam int HW = NW - LW;
  localparam int XW = SW + MARGIN_FRAC_BITS + MW + 1;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] en;

  logic signed [DW-1:0] e1x_nxt, e1y_nxt, e2x_nxt, e2y_nxt, wx_nxt, wy_nxt;
  logic signed [DW-1:0] e1x_r, e1y_r, e2x_r, e2y_r, wx_r, wy_r;

  logic signed [PW-1:0] pd1_nxt, pd2_nxt, pu1_nxt, pu2_nxt, pv1_nxt, pv2_nxt;
  logic signed [PW-1:0] pd1_r, pd2_r, pu1_r, pu2_r, pv1_r, pv2_r;

  logic signed [NW-1:0] det3_nxt, nu3_nxt, nv3_nxt;
  logic signed [NW-1:0] det3_r, nu3_r, nv3_r;

  logic signed [NW-1:0] dabs4_nxt, nu4_nxt, nv4_nxt;
  logic signed [NW-1:0] dabs4_r, nu4_r, nv4_r;
  logic signed [SW-1:0] sum4_nxt, sum4_r;
  logic                 neg4_nxt, neg4_r, zero4_nxt, zero4_r;

  logic signed [NW-1:0] dabs5_r, nu5_r, nv5_r;
  logic signed [SW-1:0] sum5_nxt, sum5_r;
  logic [LW+MW-1:0]     pl5_nxt, pl5_r;
  logic [HW+MW-1:0]     ph5_nxt, ph5_r;
  logic                 zero5_r;

  logic signed [XW-1:0] lim6_nxt, su6_nxt, sv6_nxt, ss6_nxt, dsh6_nxt;
  logic signed [XW-1:0] lim6_r, su6_r, sv6_r, ss6_r, dsh6_r;
  logic                 zero6_r;

  logic signed [XW-1:0] upper7_nxt, upper7_r, ss7_r;
  logic                 pass7_nxt, pass7_r;

  logic                 inside8_nxt, inside8_r;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_comb begin
    e1x_nxt = DW'(in_coord[IDX_BX]) - DW'(in_coord[IDX_AX]);
    e1y_nxt = DW'(in_coord[IDX_BY]) - DW'(in_coord[IDX_AY]);
    e2x_nxt = DW'(in_coord[IDX_CX]) - DW'(in_coord[IDX_AX]);
    e2y_nxt = DW'(in_coord[IDX_CY]) - DW'(in_coord[IDX_AY]);
    wx_nxt  = DW'(in_coord[IDX_QX]) - DW'(in_coord[IDX_AX]);
    wy_nxt  = DW'(in_coord[IDX_QY]) - DW'(in_coord[IDX_AY]);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      e1x_r <= e1x_nxt;
      e1y_r <= e1y_nxt;
      e2x_r <= e2x_nxt;
      e2y_r <= e2y_nxt;
      wx_r  <= wx_nxt;
      wy_r  <= wy_nxt;
    end
  end

  always_comb begin
    pd1_nxt = PW'(e1x_r) * PW'(e2y_r);
    pd2_nxt = PW'(e1y_r) * PW'(e2x_r);
    pu1_nxt = PW'(wx_r) * PW'(e2y_r);
    pu2_nxt = PW'(wy_r) * PW'(e2x_r);
    pv1_nxt = PW'(e1x_r) * PW'(wy_r);
    pv2_nxt = PW'(e1y_r) * PW'(wx_r);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pd1_r <= pd1_nxt;
      pd2_r <= pd2_nxt;
      pu1_r <= pu1_nxt;
      pu2_r <= pu2_nxt;
      pv1_r <= pv1_nxt;
      pv2_r <= pv2_nxt;
    end
  end

  always_comb begin
    det3_nxt = NW'(pd1_r) - NW'(pd2_r);
    nu3_nxt  = NW'(pu1_r) - NW'(pu2_r);
    nv3_nxt  = NW'(pv1_r) - NW'(pv2_r);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      det3_r <= det3_nxt;
      nu3_r  <= nu3_nxt;
      nv3_r  <= nv3_nxt;
    end
  end

  always_comb begin
    neg4_nxt  = det3_r[NW-1];
    zero4_nxt = (det3_r == '0);
    dabs4_nxt = neg4_nxt ? -det3_r : det3_r;
    nu4_nxt   = neg4_nxt ? -nu3_r : nu3_r;
    nv4_nxt   = neg4_nxt ? -nv3_r : nv3_r;
    sum4_nxt  = SW'(nu3_r) + SW'(nv3_r);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      neg4_r  <= neg4_nxt;
      zero4_r <= zero4_nxt;
      dabs4_r <= dabs4_nxt;
      nu4_r   <= nu4_nxt;
      nv4_r   <= nv4_nxt;
      sum4_r  <= sum4_nxt;
    end
  end

  always_comb begin
    sum5_nxt = neg4_r ? -sum4_r : sum4_r;
    pl5_nxt  = (LW+MW)'(dabs4_r[LW-1:0]) * (LW+MW)'(margin);
    ph5_nxt  = (HW+MW)'(dabs4_r[NW-1:LW]) * (HW+MW)'(margin);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sum5_r  <= sum5_nxt;
      pl5_r   <= pl5_nxt;
      ph5_r   <= ph5_nxt;
      dabs5_r <= dabs4_r;
      nu5_r   <= nu4_r;
      nv5_r   <= nv4_r;
      zero5_r <= zero4_r;
    end
  end

  always_comb begin
    lim6_nxt = $signed(XW'(pl5_r) + (XW'(ph5_r) << LW));
    su6_nxt  = XW'(nu5_r) <<< MARGIN_FRAC_BITS;
    sv6_nxt  = XW'(nv5_r) <<< MARGIN_FRAC_BITS;
    ss6_nxt  = XW'(sum5_r) <<< MARGIN_FRAC_BITS;
    dsh6_nxt = XW'(dabs5_r) <<< MARGIN_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      lim6_r  <= lim6_nxt;
      su6_r   <= su6_nxt;
      sv6_r   <= sv6_nxt;
      ss6_r   <= ss6_nxt;
      dsh6_r  <= dsh6_nxt;
      zero6_r <= zero5_r;
    end
  end

  always_comb begin
    upper7_nxt = dsh6_r - lim6_r;
    pass7_nxt  = !zero6_r && (lim6_r < su6_r) && (lim6_r < sv6_r);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      upper7_r <= upper7_nxt;
      ss7_r    <= ss6_r;
      pass7_r  <= pass7_nxt;
    end
  end

  assign inside8_nxt = pass7_r && (ss7_r < upper7_r);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      inside8_r <= inside8_nxt;
    end
  end

  assign in_ready   = en[0];
  assign out_valid  = vld_r[NUM_STAGES-1];
  assign out_inside = inside8_r;

endmodule

// ===== sv/triangle_point_containment_unit.sv =====
// ----------------------------------------------------------------------------
// triangle_point_containment_unit
// Tests whether a query point lies strictly inside a triangle, beyond a
// programmable barycentric margin, in exact integer arithmetic.
// ----------------------------------------------------------------------------
// The unit accepts one query transaction per clock cycle unless the result
// channel stalls a full pipeline, and returns one result per query, in order.
// The datapath has eight register stages, one of which holds the
// cross-product multipliers and one the margin multiplier. Each stage only
// holds while its successor is full, so queries keep entering while a result
// waits to be taken, until every stage is full. The margin register at byte
// address 0 may only be written while no query is in flight.
module triangle_point_containment_unit #(
  parameter int COORD_WIDTH      = tpc_pkg::DEF_COORD_WIDTH,
  parameter int MARGIN_FRAC_BITS = tpc_pkg::DEF_MARGIN_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  tpc_in_if.sink                               in_chan,
  tpc_out_if.source                            out_chan,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [tpc_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [tpc_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [tpc_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                 pready
);
  import tpc_pkg::*;

  logic [MARGIN_WIDTH-1:0]       margin_r;
  logic [MARGIN_WIDTH-1:0]       margin_nxt;
  logic                          cfg_wr;
  logic                          cfg_hit;
  logic signed [COORD_WIDTH-1:0] coord [NUM_COORDS];

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[APB_ADDR_WIDTH-1:2] == REG_MARGIN);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    margin_nxt = margin_r;
    if (cfg_wr && cfg_hit) begin
      margin_nxt = pwdata[MARGIN_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= '0;
    end else begin
      margin_r <= margin_nxt;
    end
  end

  assign prdata = cfg_hit ? APB_DATA_WIDTH'(margin_r) : '0;

  assign coord[IDX_AX] = in_chan.vertex_a_x;
  assign coord[IDX_AY] = in_chan.vertex_a_y;
  assign coord[IDX_BX] = in_chan.vertex_b_x;
  assign coord[IDX_BY] = in_chan.vertex_b_y;
  assign coord[IDX_CX] = in_chan.vertex_c_x;
  assign coord[IDX_CY] = in_chan.vertex_c_y;
  assign coord[IDX_QX] = in_chan.query_x;
  assign coord[IDX_QY] = in_chan.query_y;

  tpc_pipe #(
    .COORD_WIDTH      (COORD_WIDTH),
    .MARGIN_FRAC_BITS (MARGIN_FRAC_BITS)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_coord   (coord),
    .margin     (margin_r),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_inside (out_chan.inside_res)
  );

  a_stall_only_when_blocked : assert property (
    @(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready)
  ) else $error("Input stalled while the result stage could drain.");

  a_margin_write : assert property (
    @(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(cfg_wr && cfg_hit)) |->
      (margin_r == $past(pwdata[MARGIN_WIDTH-1:0]))
  ) else $error("Margin register did not take the written value.");

  a_margin_hold : assert property (
    @(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(cfg_wr)) |-> $stable(margin_r)
  ) else $error("Margin register changed without a write transaction.");

endmodule

// ===== tb/sv/tb_triangle_point_containment_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_point_containment_unit
// Self-checking testbench for the triangle point containment unit. Queries
// are streamed in with random gaps and results taken with random backpressure,
// except in steady phases that run both unthrottled, and compared in order
// with an exact integer model of the barycentric test. The margin register is
// swept over several values, the extremes among them, while the unit is idle.
// ----------------------------------------------------------------------------
module tb_triangle_point_containment_unit;

  import tpc_pkg::*;

  localparam int CW         = DEF_COORD_WIDTH;
  localparam int FRAC       = DEF_MARGIN_FRAC_BITS;
  localparam int WSUM       = 1024;
  localparam int PHASE_SIZE = 142;
  localparam int IDLE_LIMIT = 1000;

  localparam logic [APB_ADDR_WIDTH-1:0] MARGIN_ADDR   = {REG_MARGIN, 2'b00};
  localparam logic [APB_ADDR_WIDTH-1:0] UNMAPPED_ADDR = MARGIN_ADDR + 3'd4;

  typedef struct {
    logic signed [CW-1:0] ax, ay, bx, by, cx, cy, qx, qy;
  } query_t;

  typedef int coord_set_t [NUM_COORDS];

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [APB_ADDR_WIDTH-1:0] paddr;
  logic [APB_DATA_WIDTH-1:0] pwdata, prdata;

  tpc_in_if  in_chan ();
  tpc_out_if out_chan ();

  triangle_point_containment_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk = ~clk;

  query_t                  pending_queries [$];
  logic                    expected_inside [$];
  query_t                  driven_query;
  logic [MARGIN_WIDTH-1:0] margin_cfg;
  bit                      steady;
  bit                      launch_next;
  int                      send_gap;
  int                      recv_hold;
  int                      error_count;
  int                      accepted_count;
  int                      result_count;
  int                      inside_count;
  int                      margin_settings;
  int                      idle_cycles;

  function automatic logic predict_inside(query_t q, logic [MARGIN_WIDTH-1:0] margin);
    logic signed [127:0] e1x, e1y, e2x, e2y, wx, wy;
    logic signed [127:0] det, nu, nv, margin_w, lim, upper;
    e1x = q.bx - q.ax;
    e1y = q.by - q.ay;
    e2x = q.cx - q.ax;
    e2y = q.cy - q.ay;
    wx  = q.qx - q.ax;
    wy  = q.qy - q.ay;
    det = e1x * e2y - e1y * e2x;
    nu  = wx * e2y - wy * e2x;
    nv  = e1x * wy - e1y * wx;
    if (det == 0) begin
      return 1'b0;
    end
    if (det < 0) begin
      det = -det;
      nu  = -nu;
      nv  = -nv;
    end
    margin_w = {112'd0, margin};
    lim      = det * margin_w;
    upper    = (det <<< FRAC) - lim;
    return (lim < (nu <<< FRAC)) && (lim < (nv <<< FRAC)) &&
           (((nu + nv) <<< FRAC) < upper);
  endfunction

  function automatic query_t pack_query(coord_set_t c);
    query_t q;
    q.ax = CW'(c[IDX_AX]);
    q.ay = CW'(c[IDX_AY]);
    q.bx = CW'(c[IDX_BX]);
    q.by = CW'(c[IDX_BY]);
    q.cx = CW'(c[IDX_CX]);
    q.cy = CW'(c[IDX_CY]);
    q.qx = CW'(c[IDX_QX]);
    q.qy = CW'(c[IDX_QY]);
    return q;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int sat_coord(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int edge_coord();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic query_t random_query();
    coord_set_t c;
    int kind, w0, w1, w2, base_x, base_y, dx, dy, k;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < NUM_COORDS; i++) begin
      c[i] = rand_coord();
    end
    if (kind < 25) begin
      return pack_query(c);
    end else if (kind < 60) begin
      w1 = $urandom_range(0, WSUM);
      w2 = $urandom_range(0, WSUM - w1);
      if ($urandom_range(0, 1) == 1) begin
        w0 = w1;
        w1 = w2;
        w2 = w0;
      end
      w0 = WSUM - w1 - w2;
      c[IDX_QX] = sat_coord((w0 * c[IDX_AX] + w1 * c[IDX_BX] + w2 * c[IDX_CX]) / WSUM
                            + int'($urandom_range(0, 2)) - 1);
      c[IDX_QY] = sat_coord((w0 * c[IDX_AY] + w1 * c[IDX_BY] + w2 * c[IDX_CY]) / WSUM
                            + int'($urandom_range(0, 2)) - 1);
    end else if (kind < 75) begin
      base_x = int'($urandom_range(0, 64000)) - 32000;
      base_y = int'($urandom_range(0, 64000)) - 32000;
      for (int i = 0; i < NUM_COORDS; i += 2) begin
        c[i]     = base_x + int'($urandom_range(0, 16)) - 8;
        c[i + 1] = base_y + int'($urandom_range(0, 16)) - 8;
      end
    end else if (kind < 87) begin
      base_x = int'($urandom_range(0, 20000)) - 10000;
      base_y = int'($urandom_range(0, 20000)) - 10000;
      dx = int'($urandom_range(0, 200)) - 100;
      dy = int'($urandom_range(0, 200)) - 100;
      c[IDX_AX] = base_x;
      c[IDX_AY] = base_y;
      k = int'($urandom_range(0, 100)) - 50;
      c[IDX_BX] = base_x + k * dx;
      c[IDX_BY] = base_y + k * dy;
      k = int'($urandom_range(0, 100)) - 50;
      c[IDX_CX] = base_x + k * dx;
      c[IDX_CY] = base_y + k * dy;
      k = int'($urandom_range(0, 100)) - 50;
      c[IDX_QX] = base_x + k * dx + int'($urandom_range(0, 2)) - 1;
      c[IDX_QY] = base_y + k * dy;
    end else begin
      for (int i = 0; i < NUM_COORDS; i++) begin
        c[i] = edge_coord();
      end
    end
    return pack_query(c);
  endfunction

  task automatic log_failure(string msg);
    error_count++;
    if (error_count <= 10) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  task automatic apb_write(logic [APB_ADDR_WIDTH-1:0] addr, logic [APB_DATA_WIDTH-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_margin_readback();
    logic [APB_DATA_WIDTH-1:0] data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MARGIN_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (data !== APB_DATA_WIDTH'(margin_cfg)) begin
      log_failure($sformatf("Margin readback: expected %h, got %h",
                            APB_DATA_WIDTH'(margin_cfg), data));
    end
  endtask

  task automatic set_margin(logic [APB_DATA_WIDTH-1:0] data);
    apb_write(MARGIN_ADDR, data);
    margin_cfg = data[MARGIN_WIDTH-1:0];
    margin_settings++;
    check_margin_readback();
  endtask

  task automatic wait_for_drain();
    while (pending_queries.size() != 0 || expected_inside.size() != 0) @(posedge clk);
    repeat (NUM_STAGES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        expected_inside.push_back(predict_inside(driven_query, margin_cfg));
        void'(pending_queries.pop_front());
        accepted_count++;
        send_gap    = steady ? 0 : pick_gap();
        launch_next = 1'b1;
      end else begin
        launch_next = !in_chan.valid;
      end
      if (launch_next) begin
        if (send_gap > 0) begin
          send_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_queries.size() > 0) begin
          driven_query = pending_queries[0];
          in_chan.vertex_a_x <= driven_query.ax;
          in_chan.vertex_a_y <= driven_query.ay;
          in_chan.vertex_b_x <= driven_query.bx;
          in_chan.vertex_b_y <= driven_query.by;
          in_chan.vertex_c_x <= driven_query.cx;
          in_chan.vertex_c_y <= driven_query.cy;
          in_chan.query_x    <= driven_query.qx;
          in_chan.query_y    <= driven_query.qy;
          in_chan.valid      <= 1'b1;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        result_count++;
        if (out_chan.inside_res === 1'b1) inside_count++;
        if (expected_inside.size() == 0) begin
          log_failure($sformatf("Result transaction %0d arrived with no query outstanding",
                                result_count));
        end else if (out_chan.inside_res !== expected_inside[0]) begin
          log_failure($sformatf("Mismatch on result %0d: expected inside_res=%0b, got %0b",
                                result_count, expected_inside[0], out_chan.inside_res));
          void'(expected_inside.pop_front());
        end else begin
          void'(expected_inside.pop_front());
        end
      end
      if (recv_hold > 0) begin
        recv_hold--;
        out_chan.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 9) == 0) begin
        recv_hold = pick_gap();
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || psel) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [MARGIN_WIDTH-1:0] phase_margins [8];
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_chan.valid      = 1'b0;
    in_chan.vertex_a_x = '0;
    in_chan.vertex_a_y = '0;
    in_chan.vertex_b_x = '0;
    in_chan.vertex_b_y = '0;
    in_chan.vertex_c_x = '0;
    in_chan.vertex_c_y = '0;
    in_chan.query_x    = '0;
    in_chan.query_y    = '0;
    out_chan.ready     = 1'b0;
    margin_cfg         = '0;
    steady             = 1'b0;
    error_count        = 0;
    accepted_count     = 0;
    result_count       = 0;
    inside_count       = 0;
    margin_settings    = 1;
    idle_cycles        = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_margin_readback();

    pending_queries.push_back(pack_query('{0, 0, 100, 0, 0, 100, 10, 10}));
    pending_queries.push_back(pack_query('{0, 0, 0, 100, 100, 0, 10, 10}));
    pending_queries.push_back(pack_query('{0, 0, 100, 0, 0, 100, 200, 200}));
    pending_queries.push_back(pack_query('{0, 0, 100, 0, 0, 100, 50, 0}));
    pending_queries.push_back(pack_query('{0, 0, 100, 0, 0, 100, 0, 0}));
    pending_queries.push_back(pack_query('{0, 0, 100, 0, 0, 100, 50, 50}));
    pending_queries.push_back(pack_query('{0, 0, 100, 0, 0, 100, 1, 1}));
    pending_queries.push_back(pack_query('{0, 0, 3, 0, 0, 3, 1, 1}));
    pending_queries.push_back(pack_query('{5, 5, 5, 5, 5, 5, 5, 5}));
    pending_queries.push_back(pack_query('{0, 0, 10, 10, 20, 20, 5, 5}));
    pending_queries.push_back(pack_query('{-32768, -32768, 32767, -32768, -32768, 32767, -1, -1}));
    pending_queries.push_back(pack_query('{-32768, -32768, -32768, 32767, 32767, -32768, -1, -1}));
    pending_queries.push_back(pack_query('{-32768, -32768, 32767, -32768, -32768, 32767, 0, 0}));
    pending_queries.push_back(pack_query('{-32768, -32768, 32767, -32768, -32768, 32767,
                                           32767, 32767}));
    pending_queries.push_back(pack_query('{32767, 32767, -32768, 32767, 32767, -32768, 0, 0}));
    pending_queries.push_back(pack_query('{-32768, -32768, -32768, -32768, -32768, -32768,
                                           -32768, -32768}));
    pending_queries.push_back(pack_query('{32767, 32767, 32767, 32767, 32767, 32767,
                                           32767, 32767}));
    pending_queries.push_back(pack_query('{-1, 0, 0, -1, -1, -1, 0, 0}));
    pending_queries.push_back(pack_query('{32767, -32768, -32768, 32767, 32767, 32767,
                                           32767, 0}));
    pending_queries.push_back(pack_query('{-10, -10, 10, -10, 0, 10, 0, 0}));
    wait_for_drain();

    // A write to an unmapped address must leave the margin untouched.
    apb_write(UNMAPPED_ADDR, 32'h0000_1234);
    check_margin_readback();

    phase_margins = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
                      16'h7FFF, 16'h1000, 16'h0000, 16'h0000};
    phase_margins[6] = MARGIN_WIDTH'($urandom_range(0, 65535));
    phase_margins[7] = MARGIN_WIDTH'($urandom_range(0, 16383));
    for (int p = 0; p < 8; p++) begin
      if (p == 1) begin
        set_margin({16'hA5C3, phase_margins[p]});
      end else begin
        set_margin(APB_DATA_WIDTH'(phase_margins[p]));
      end
      steady = (p % 3 == 2);
      for (int n = 0; n < PHASE_SIZE; n++) begin
        pending_queries.push_back(random_query());
      end
      wait_for_drain();
    end
    steady = 1'b0;

    $display("Covered %0d queries across %0d margin settings, %0d of them reported inside.",
             accepted_count, margin_settings, inside_count);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures recorded", error_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
